### design/tftpc_pkg.sv
package tftpc_pkg;

	// Field widths
	localparam int unsigned PORT_W  = 16;
	localparam int unsigned OP_W    = 16;
	localparam int unsigned BLK_W   = 16;
	localparam int unsigned LEN_W   = 10;
	localparam int unsigned ERRC_W  = 16;
	localparam int unsigned RETRY_W = 16;
	localparam int unsigned PERR_W  = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Full data segment size in bytes
	localparam logic [LEN_W-1:0] SEGMENT_BYTES = LEN_W'(512);

	// TFTP opcodes
	localparam logic [OP_W-1:0] OP_DATA  = OP_W'(3);
	localparam logic [OP_W-1:0] OP_ACK   = OP_W'(4);
	localparam logic [OP_W-1:0] OP_ERROR = OP_W'(5);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SERVER_PORT = 2'd2;

	// Reset values of configuration registers
	localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = RETRY_W'(5);
	localparam logic [PORT_W-1:0]  SERVER_PORT_RST = PORT_W'(69);

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_PACKET  = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_ADVANCE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_RESEND  = 3'd0,
		ACT_ACCEPT  = 3'd1,
		ACT_PEERERR = 3'd2,
		ACT_SYNC    = 3'd3,
		ACT_TIMEOUT = 3'd4,
		ACT_DONE    = 3'd5
	} act_t;

	// One event item
	typedef struct packed {
		cmd_t               cmd;
		logic [PORT_W-1:0]  src_port;
		logic [OP_W-1:0]    opcode;
		logic [BLK_W-1:0]   block_num;
		logic [LEN_W-1:0]   payload_len;
		logic [ERRC_W-1:0]  err_code;
	} evt_item_t;

	// Input stage to core
	typedef struct packed {
		logic      valid;
		evt_item_t item;
	} stage_t;

	// Configuration as seen by the core
	typedef struct packed {
		logic               direction;
		logic [RETRY_W-1:0] retry_limit;
		logic [PORT_W-1:0]  server_port;
	} cfg_t;

endpackage

### design/tftpc_evt_if.sv
interface tftpc_evt_if
	import tftpc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [1:0]           cmd;
	logic [PORT_W-1:0]    src_port;
	logic [OP_W-1:0]      opcode;
	logic [BLK_W-1:0]     block_num;
	logic [LEN_W-1:0]     payload_len;
	logic [ERRC_W-1:0]    err_code;

	modport source (
		output valid, cmd, src_port, opcode, block_num, payload_len, err_code,
		input  ready
	);
	modport sink (
		input  valid, cmd, src_port, opcode, block_num, payload_len, err_code,
		output ready
	);
endinterface

### design/tftpc_res_if.sv
interface tftpc_res_if
	import tftpc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [2:0]           action;
	logic [LEN_W-1:0]     data_len;
	logic                 at_eof;
	logic [PERR_W-1:0]    peer_error;
	logic [BLK_W-1:0]     cur_block;
	logic [PORT_W-1:0]    peer_port;

	modport source (
		output valid, action, data_len, at_eof, peer_error, cur_block, peer_port,
		input  ready
	);
	modport sink (
		input  valid, action, data_len, at_eof, peer_error, cur_block, peer_port,
		output ready
	);
endinterface

### design/tftpc_in_stage.sv
module tftpc_in_stage
	import tftpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tftpc_evt_if.sink          evt,
	input  logic               fire,
	output stage_t             stage
);

	logic      valid_s1;
	evt_item_t item_s1;
	logic      take;

	// Room when empty or when the held item moves on this cycle
	assign evt.ready = !valid_s1 || fire;
	assign take      = evt.valid && evt.ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	// Item payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd         <= cmd_t'(evt.cmd);
			item_s1.src_port    <= evt.src_port;
			item_s1.opcode      <= evt.opcode;
			item_s1.block_num   <= evt.block_num;
			item_s1.payload_len <= evt.payload_len;
			item_s1.err_code    <= evt.err_code;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = item_s1;

endmodule

### design/tftpc_core.sv
module tftpc_core
	import tftpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  stage_t             stage,
	output logic               fire,
	tftpc_res_if.source        res
);

	// Transfer state
	logic [BLK_W-1:0]   exp_blk_q;
	logic [PORT_W-1:0]  lock_port_q;
	logic [RETRY_W-1:0] retry_q;
	logic               eof_q;

	// Result register
	logic               res_valid_q;
	act_t               act_q;
	logic [LEN_W-1:0]   dlen_q;
	logic [PERR_W-1:0]  perr_q;

	// Next values
	logic [BLK_W-1:0]   exp_blk_n;
	logic [PORT_W-1:0]  lock_port_n;
	logic [RETRY_W-1:0] retry_n;
	logic               eof_n;
	act_t               act_n;
	logic [LEN_W-1:0]   dlen_n;
	logic [PERR_W-1:0]  perr_n;

	logic               learn;
	logic [OP_W-1:0]    want_op;
	logic [BLK_W-1:0]   prev_blk;
	logic [RETRY_W-1:0] retry_inc;
	evt_item_t          it;

	assign it   = stage.item;
	assign fire = stage.valid && (!res_valid_q || res.ready);

	assign learn     = cfg.direction ? (exp_blk_q == '0) : (exp_blk_q <= BLK_W'(1));
	assign want_op   = cfg.direction ? OP_ACK : OP_DATA;
	assign prev_blk  = exp_blk_q - BLK_W'(1);
	assign retry_inc = (retry_q == '1) ? retry_q : retry_q + RETRY_W'(1);

	// Per-event decision
	always_comb begin
		exp_blk_n   = exp_blk_q;
		lock_port_n = lock_port_q;
		retry_n     = retry_q;
		eof_n       = eof_q;
		act_n       = ACT_RESEND;
		dlen_n      = '0;
		perr_n      = '0;
		case (it.cmd)
			CMD_START: begin
				exp_blk_n   = cfg.direction ? BLK_W'(0) : BLK_W'(1);
				lock_port_n = cfg.server_port;
				retry_n     = '0;
				eof_n       = 1'b0;
			end
			CMD_PACKET: begin
				if (learn) begin
					lock_port_n = it.src_port;
				end
				if (!learn && (it.src_port != lock_port_q)) begin
					act_n = ACT_RESEND;
				end else if (it.opcode == OP_ERROR) begin
					act_n  = ACT_PEERERR;
					perr_n = it.err_code[PERR_W-1:0];
				end else if (it.opcode != want_op) begin
					act_n = ACT_RESEND;
				end else if (it.block_num == exp_blk_q) begin
					act_n   = ACT_ACCEPT;
					retry_n = '0;
					if (!cfg.direction) begin
						dlen_n = (it.payload_len > SEGMENT_BYTES) ? SEGMENT_BYTES
							: it.payload_len;
						if (it.payload_len < SEGMENT_BYTES) begin
							eof_n = 1'b1;
						end
					end
				end else if (it.block_num == prev_blk) begin
					act_n = ACT_RESEND;
				end else begin
					act_n = ACT_SYNC;
				end
			end
			CMD_TIMEOUT: begin
				retry_n = retry_inc;
				act_n   = (retry_inc > cfg.retry_limit) ? ACT_TIMEOUT : ACT_RESEND;
			end
			CMD_ADVANCE: begin
				exp_blk_n = exp_blk_q + BLK_W'(1);
				retry_n   = '0;
				act_n     = (!cfg.direction && eof_q) ? ACT_DONE : ACT_RESEND;
			end
			default: begin
				act_n = ACT_RESEND;
			end
		endcase
	end

	// State update, one event per fire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_blk_q   <= '0;
			lock_port_q <= '0;
			retry_q     <= '0;
			eof_q       <= 1'b0;
		end else if (fire) begin
			exp_blk_q   <= exp_blk_n;
			lock_port_q <= lock_port_n;
			retry_q     <= retry_n;
			eof_q       <= eof_n;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			act_q  <= act_n;
			dlen_q <= dlen_n;
			perr_q <= perr_n;
		end
	end

	// Block, port and eof reported after the step are the state registers
	assign res.valid      = res_valid_q;
	assign res.action     = act_q;
	assign res.data_len   = dlen_q;
	assign res.at_eof     = eof_q;
	assign res.peer_error = perr_q;
	assign res.cur_block  = exp_blk_q;
	assign res.peer_port  = lock_port_q;

endmodule

### design/tftp_client_transfer_checker.sv
// Channel  Dir  Item carries
// evt      in   cmd, src_port, opcode, block_num, payload_len, err_code
// res      out  action, data_len, at_eof, peer_error, cur_block, peer_port
// cfg      in   cfg_we, cfg_idx, cfg_data (0 direction, 1 retry_limit, 2 server_port)
//
// One item per cycle sustained while res is ready; a stalled result holds the
// flow. An event is taken into the input register, then decided from the input
// register straight into the result register, which makes the result valid.
// The state registers update when the result is loaded.
// Reset clears transfer state and loads configuration defaults. A stalled
// result holds the input register; ready toward evt drops only when both are
// full and the result is not taken in that cycle.
module tftp_client_transfer_checker
	import tftpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tftpc_evt_if.sink             evt,
	tftpc_res_if.source           res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	stage_t stage;
	logic   fire;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction   <= 1'b0;
			cfg_q.retry_limit <= RETRY_LIMIT_RST;
			cfg_q.server_port <= SERVER_PORT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DIRECTION:   cfg_q.direction   <= cfg_data[0];
				CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data[RETRY_W-1:0];
				CFG_SERVER_PORT: cfg_q.server_port <= cfg_data[PORT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tftpc_in_stage u_in_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.fire   (fire),
		.stage  (stage)
	);

	tftpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.stage  (stage),
		.fire   (fire),
		.res    (res)
	);

endmodule
